// ===== rtl/mtr_pkg.sv =====
// Shared widths, register map and constants for the top-k softmax router.
// Used by every file in rtl/; depends on nothing.
package mtr_pkg;

    localparam int LOGIT_W     = 16;
    localparam int EXP_W       = 17;
    localparam int WEIGHT_W    = 17;
    localparam int INDEX_W     = 8;
    localparam int NE_W        = 9;
    localparam int NS_W        = 7;
    localparam int SUM_W       = 25;
    localparam int NUM_W       = 33;
    localparam int PROD_W      = 33;
    localparam int FRAC_W      = 18;
    localparam int IP_W        = 7;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam int DEF_MAX_EXPERTS  = 256;
    localparam int DEF_MAX_SELECTED = 64;

    localparam logic [1:0] REG_NUM_EXPERTS  = 2'd0;
    localparam logic [1:0] REG_NUM_SELECTED = 2'd1;
    localparam logic [1:0] REG_NORMALIZE    = 2'd2;

    localparam logic [NE_W-1:0] NUM_EXPERTS_RST  = 9'd128;
    localparam logic [NS_W-1:0] NUM_SELECTED_RST = 7'd8;

    localparam logic [16:0] LOG2E_Q16   = 17'd94548;
    localparam logic [16:0] WEIGHT_ONE  = 17'd65536;

    function automatic logic [16:0] pow2_frac(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/mtr_if.sv =====
// Valid/ready channel interfaces for logits in and gating results out.
// Depends on mtr_pkg for field widths.
interface mtr_logit_if;
    logic                               valid;
    logic                               ready;
    logic signed [mtr_pkg::LOGIT_W-1:0] logit;
    modport source (output valid, output logit, input ready);
    modport sink (input valid, input logit, output ready);
endinterface

interface mtr_result_if;
    logic                          valid;
    logic                          ready;
    logic [mtr_pkg::INDEX_W-1:0]   expert_index;
    logic [mtr_pkg::WEIGHT_W-1:0]  weight;
    logic                          last_of_run;
    modport source (output valid, output expert_index, output weight, output last_of_run,
                    input ready);
    modport sink (input valid, input expert_index, input weight, input last_of_run,
                  output ready);
endinterface

// ===== rtl/moe_topk_router_top.sv =====
// Top-k softmax gating router: logit load, exponential pass, argmax selection, weighting.
// Depends on mtr_pkg, mtr_if, mtr_exp and mtr_div.
//
// Logits are taken one per cycle until num_experts have arrived; the block then stops
// accepting. The exponential pass runs each expert in turn through the shared exp unit,
// each of the k = num_selected selection passes scans all num_experts entries on the
// single read port of the exponential store, and each result goes through the bit-serial
// divider and then waits for the consumer.
module moe_topk_router_top
#(
    parameter int MAX_EXPERTS  = mtr_pkg::DEF_MAX_EXPERTS,
    parameter int MAX_SELECTED = mtr_pkg::DEF_MAX_SELECTED
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    mtr_logit_if.sink                        logit_ch,
    mtr_result_if.source                     result_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mtr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mtr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mtr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int IDX_W  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int CNT_W  = $clog2(MAX_EXPERTS + 1);
    localparam int SEL_W  = (MAX_SELECTED > 1) ? $clog2(MAX_SELECTED) : 1;

    typedef enum logic [3:0] {
        S_LOAD, S_EXP_RD, S_EXP_GO, S_EXP_WAIT,
        S_SEL_SCAN, S_SEL_DRAIN, S_SEL_COMMIT,
        S_OUT_PICK, S_OUT_EX, S_OUT_DIV, S_OUT_WAIT, S_OUT_SEND
    } state_t;

    state_t                          state_reg;
    logic [mtr_pkg::NE_W-1:0]        num_experts_reg;
    logic [mtr_pkg::NS_W-1:0]        num_selected_reg;
    logic                            normalize_reg;
    logic [CNT_W-1:0]                loaded_reg;
    logic signed [mtr_pkg::LOGIT_W-1:0] max_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [IDX_W-1:0]                scan_reg;
    logic [SEL_W-1:0]                sel_reg;
    logic                            have_prev_reg;
    logic [mtr_pkg::EXP_W-1:0]       prev_e_reg;
    logic [IDX_W-1:0]                prev_idx_reg;
    logic [mtr_pkg::SUM_W-1:0]       sum_reg;
    logic [mtr_pkg::SUM_W-1:0]       sel_sum_reg;
    logic                            cmp_v_reg;
    logic [IDX_W-1:0]                cmp_idx_reg;
    logic                            found_reg;
    logic [IDX_W-1:0]                best_reg;
    logic [mtr_pkg::EXP_W-1:0]       best_e_reg;
    logic                            out_valid_reg;
    logic [mtr_pkg::INDEX_W-1:0]     out_index_reg;
    logic [mtr_pkg::WEIGHT_W-1:0]    out_weight_reg;
    logic                            out_last_reg;

    logic [mtr_pkg::LOGIT_W-1:0]     score_mem [MAX_EXPERTS];
    logic [mtr_pkg::LOGIT_W-1:0]     score_rdata_reg;
    logic [mtr_pkg::EXP_W-1:0]       ex_mem [MAX_EXPERTS];
    logic [mtr_pkg::EXP_W-1:0]       ex_rdata_reg;
    logic [IDX_W-1:0]                pick_mem [MAX_SELECTED];
    logic [IDX_W-1:0]                pick_rdata_reg;

    logic [mtr_pkg::NE_W-1:0]        ne_eff;
    logic [mtr_pkg::NE_W-1:0]        k_eff;
    logic [mtr_pkg::NE_W-1:0]        k_clamp;
    logic                            cfg_wr;
    logic                            load_acc;
    logic                            score_we;
    logic                            ex_we;
    logic [IDX_W-1:0]                ex_raddr;
    logic                            pick_we;
    logic signed [mtr_pkg::LOGIT_W:0] diff;
    logic [mtr_pkg::LOGIT_W-1:0]     d_val;
    logic                            exp_start;
    logic                            exp_done;
    logic [mtr_pkg::EXP_W-1:0]       exp_e;
    logic                            div_start;
    logic                            div_done;
    logic [mtr_pkg::WEIGHT_W-1:0]    div_q;
    logic [mtr_pkg::SUM_W-1:0]       den;
    logic [mtr_pkg::NUM_W-1:0]       num;
    logic                            scan_last;
    logic                            exp_last;
    logic                            sel_last;
    logic                            cand_ok;

    always_comb
    begin
        if (num_experts_reg == '0)
            ne_eff = 9'd1;
        else if (num_experts_reg > 9'(MAX_EXPERTS))
            ne_eff = 9'(MAX_EXPERTS);
        else
            ne_eff = num_experts_reg;
        if (num_selected_reg == '0)
            k_clamp = 9'd1;
        else if (9'(num_selected_reg) > 9'(MAX_SELECTED))
            k_clamp = 9'(MAX_SELECTED);
        else
            k_clamp = 9'(num_selected_reg);
        k_eff = (k_clamp > ne_eff) ? ne_eff : k_clamp;
    end

    assign cfg_wr    = psel && penable && pwrite;
    assign load_acc  = logit_ch.valid && (state_reg == S_LOAD);
    assign score_we  = load_acc;
    assign ex_we     = (state_reg == S_EXP_WAIT) && exp_done;
    assign pick_we   = (state_reg == S_SEL_COMMIT);
    assign exp_start = (state_reg == S_EXP_GO);
    assign div_start = (state_reg == S_OUT_DIV);
    assign scan_last = (9'(scan_reg) == ne_eff - 9'd1);
    assign exp_last  = (9'(idx_reg) == ne_eff - 9'd1);
    assign sel_last  = (9'(sel_reg) == k_eff - 9'd1);

    always_comb
    begin
        diff = {max_reg[mtr_pkg::LOGIT_W-1], max_reg}
             - {score_rdata_reg[mtr_pkg::LOGIT_W-1], score_rdata_reg};
        d_val = diff[mtr_pkg::LOGIT_W] ? '0 : diff[mtr_pkg::LOGIT_W-1:0];
        if (state_reg == S_OUT_PICK || state_reg == S_OUT_EX || state_reg == S_OUT_DIV
            || state_reg == S_OUT_WAIT || state_reg == S_OUT_SEND)
            ex_raddr = pick_rdata_reg;
        else
            ex_raddr = scan_reg;
        den = normalize_reg ? sel_sum_reg : sum_reg;
        num = {ex_rdata_reg, 16'd0} + mtr_pkg::NUM_W'(den >> 1);
        cand_ok = !have_prev_reg || (ex_rdata_reg < prev_e_reg)
                  || ((ex_rdata_reg == prev_e_reg) && (cmp_idx_reg > prev_idx_reg));
    end

    always_ff @(posedge clk)
    begin
        if (score_we)
            score_mem[loaded_reg[IDX_W-1:0]] <= logit_ch.logit;
        score_rdata_reg <= score_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ex_we)
            ex_mem[idx_reg] <= exp_e;
        ex_rdata_reg <= ex_mem[ex_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pick_we)
            pick_mem[sel_reg] <= best_reg;
        pick_rdata_reg <= pick_mem[sel_reg];
    end

    mtr_exp u_exp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .d     (d_val),
        .done  (exp_done),
        .e     (exp_e)
    );

    mtr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            num_experts_reg  <= mtr_pkg::NUM_EXPERTS_RST;
            num_selected_reg <= mtr_pkg::NUM_SELECTED_RST;
            normalize_reg    <= 1'b1;
            loaded_reg       <= '0;
            max_reg          <= 16'sh8000;
            idx_reg          <= '0;
            scan_reg         <= '0;
            sel_reg          <= '0;
            have_prev_reg    <= 1'b0;
            prev_e_reg       <= '0;
            prev_idx_reg     <= '0;
            sum_reg          <= '0;
            sel_sum_reg      <= '0;
            cmp_v_reg        <= 1'b0;
            cmp_idx_reg      <= '0;
            found_reg        <= 1'b0;
            best_reg         <= '0;
            best_e_reg       <= '0;
            out_valid_reg    <= 1'b0;
            out_index_reg    <= '0;
            out_weight_reg   <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            cmp_v_reg   <= (state_reg == S_SEL_SCAN);
            cmp_idx_reg <= scan_reg;
            if (cmp_v_reg && cand_ok
                && (!found_reg || ex_rdata_reg > best_e_reg))
            begin
                best_reg   <= cmp_idx_reg;
                best_e_reg <= ex_rdata_reg;
                found_reg  <= 1'b1;
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (load_acc)
                    begin
                        loaded_reg <= loaded_reg + 1'b1;
                        if (logit_ch.logit > max_reg)
                            max_reg <= logit_ch.logit;
                        if (9'(loaded_reg) + 9'd1 >= ne_eff)
                        begin
                            idx_reg       <= '0;
                            sum_reg       <= '0;
                            have_prev_reg <= 1'b0;
                            state_reg     <= S_EXP_RD;
                        end
                    end
                end
                S_EXP_RD:
                    state_reg <= S_EXP_GO;
                S_EXP_GO:
                    state_reg <= S_EXP_WAIT;
                S_EXP_WAIT:
                begin
                    if (exp_done)
                    begin
                        sum_reg <= sum_reg + mtr_pkg::SUM_W'(exp_e);
                        if (exp_last)
                        begin
                            scan_reg    <= '0;
                            sel_reg     <= '0;
                            sel_sum_reg <= '0;
                            found_reg   <= 1'b0;
                            state_reg   <= S_SEL_SCAN;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_EXP_RD;
                        end
                    end
                end
                S_SEL_SCAN:
                begin
                    if (scan_last)
                        state_reg <= S_SEL_DRAIN;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_SEL_DRAIN:
                    state_reg <= S_SEL_COMMIT;
                S_SEL_COMMIT:
                begin
                    have_prev_reg <= 1'b1;
                    prev_e_reg    <= best_e_reg;
                    prev_idx_reg  <= best_reg;
                    sel_sum_reg <= sel_sum_reg + mtr_pkg::SUM_W'(best_e_reg);
                    found_reg   <= 1'b0;
                    scan_reg    <= '0;
                    if (sel_last)
                    begin
                        sel_reg   <= '0;
                        state_reg <= S_OUT_PICK;
                    end
                    else
                    begin
                        sel_reg   <= sel_reg + 1'b1;
                        state_reg <= S_SEL_SCAN;
                    end
                end
                S_OUT_PICK:
                    state_reg <= S_OUT_EX;
                S_OUT_EX:
                    state_reg <= S_OUT_DIV;
                S_OUT_DIV:
                    state_reg <= S_OUT_WAIT;
                S_OUT_WAIT:
                begin
                    if (div_done)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_index_reg  <= mtr_pkg::INDEX_W'(pick_rdata_reg);
                        out_weight_reg <= (div_q > mtr_pkg::WEIGHT_ONE)
                                          ? mtr_pkg::WEIGHT_ONE : div_q;
                        out_last_reg   <= sel_last;
                        state_reg      <= S_OUT_SEND;
                    end
                end
                S_OUT_SEND:
                begin
                    if (result_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            loaded_reg <= '0;
                            max_reg    <= 16'sh8000;
                            state_reg  <= S_LOAD;
                        end
                        else
                        begin
                            sel_reg   <= sel_reg + 1'b1;
                            state_reg <= S_OUT_PICK;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase

            if (cfg_wr)
            begin
                case (paddr[3:2])
                    mtr_pkg::REG_NUM_EXPERTS:
                    begin
                        num_experts_reg <= pwdata[mtr_pkg::NE_W-1:0];
                        loaded_reg      <= '0;
                        max_reg         <= 16'sh8000;
                    end
                    mtr_pkg::REG_NUM_SELECTED:
                    begin
                        num_selected_reg <= pwdata[mtr_pkg::NS_W-1:0];
                        loaded_reg       <= '0;
                        max_reg          <= 16'sh8000;
                    end
                    mtr_pkg::REG_NORMALIZE:
                    begin
                        normalize_reg <= pwdata[0];
                        loaded_reg    <= '0;
                        max_reg       <= 16'sh8000;
                    end
                    default:
                    begin
                        normalize_reg <= normalize_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mtr_pkg::REG_NUM_EXPERTS:  prdata = 32'(num_experts_reg);
            mtr_pkg::REG_NUM_SELECTED: prdata = 32'(num_selected_reg);
            mtr_pkg::REG_NORMALIZE:    prdata = 32'(normalize_reg);
            default:                   prdata = '0;
        endcase
    end

    assign pready                 = 1'b1;
    assign logit_ch.ready         = (state_reg == S_LOAD);
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.expert_index = out_index_reg;
    assign result_ch.weight       = out_weight_reg;
    assign result_ch.last_of_run  = out_last_reg;

endmodule

// ===== rtl/mtr_exp.sv =====
// Three-stage exponential unit: e = 2^(-d*log2(e)) in Q1.16 from a Q.10 distance.
// Depends on mtr_pkg for the fraction table and widths.
module mtr_exp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mtr_pkg::LOGIT_W-1:0] d,
    output logic                        done,
    output logic [mtr_pkg::EXP_W-1:0]   e
);

    function automatic logic [mtr_pkg::PROD_W-1:0] PROD_W_MUL(input logic [15:0] x);
        return {17'd0, x} * {16'd0, mtr_pkg::LOG2E_Q16};
    endfunction

    logic [mtr_pkg::PROD_W-1:0] prod_reg;
    logic                       v1_reg;
    logic [16:0]                pj_reg;
    logic [mtr_pkg::FRAC_W-1:0] frac_reg;
    logic [mtr_pkg::IP_W-1:0]   ip_reg;
    logic                       v2_reg;
    logic [mtr_pkg::EXP_W-1:0]  e_reg;
    logic                       done_reg;

    logic [mtr_pkg::PROD_W-1:0] rnd;
    logic [16:0]                t;
    logic [16:0]                pj;
    logic [16:0]                pj1;
    logic [11:0]                delta;
    logic [16:0]                m;
    logic [17:0]                sh;
    logic [4:0]                 shamt;
    logic [mtr_pkg::EXP_W-1:0]  e_calc;

    always_comb
    begin
        rnd   = prod_reg + 33'd32768;
        t     = rnd[32:16];
        pj    = mtr_pkg::pow2_frac({1'b0, t[9:6]});
        pj1   = mtr_pkg::pow2_frac(5'({1'b0, t[9:6]} + 5'd1));
        delta = 12'(pj - pj1);
        m     = pj_reg - 17'((frac_reg + 18'd32) >> 6);
        shamt = 5'(ip_reg - 7'd1);
        sh    = {1'b0, m} >> shamt;
        if (ip_reg == 7'd0)
            e_calc = m;
        else if (ip_reg >= 7'd32)
            e_calc = '0;
        else
            e_calc = 17'((sh + 18'd1) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            v1_reg   <= 1'b0;
            pj_reg   <= '0;
            frac_reg <= '0;
            ip_reg   <= '0;
            v2_reg   <= 1'b0;
            e_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
            if (start)
                prod_reg <= PROD_W_MUL(d);
            if (v1_reg)
            begin
                pj_reg   <= pj;
                frac_reg <= delta * t[5:0];
                ip_reg   <= t[16:10];
            end
            if (v2_reg)
                e_reg <= e_calc;
        end
    end

    assign done = done_reg;
    assign e    = e_reg;

endmodule

// ===== rtl/mtr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the weight normalization.
// Depends on mtr_pkg for operand widths.
module mtr_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mtr_pkg::NUM_W-1:0]    num,
    input  logic [mtr_pkg::SUM_W-1:0]    den,
    output logic                         done,
    output logic [mtr_pkg::WEIGHT_W-1:0] quo
);

    localparam int CNT_W = $clog2(mtr_pkg::NUM_W + 1);

    logic [mtr_pkg::NUM_W-1:0]    num_reg;
    logic [mtr_pkg::SUM_W-1:0]    den_reg;
    logic [mtr_pkg::SUM_W-1:0]    rem_reg;
    logic [mtr_pkg::WEIGHT_W-1:0] q_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [mtr_pkg::SUM_W:0]      trial;
    logic                         qbit;

    always_comb
    begin
        trial = {rem_reg, num_reg[mtr_pkg::NUM_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= CNT_W'(mtr_pkg::NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[mtr_pkg::NUM_W-2:0], 1'b0};
                q_reg   <= {q_reg[mtr_pkg::WEIGHT_W-2:0], qbit};
                if (qbit)
                    rem_reg <= mtr_pkg::SUM_W'(trial - {1'b0, den_reg});
                else
                    rem_reg <= trial[mtr_pkg::SUM_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== tb/sv/moe_topk_router_top_tb.sv =====
// Self-checking testbench for the top-k softmax router: APB setup, logit stream in,
// chosen experts with weights out, compared against a cycle-free predictor.
// Depends on mtr_pkg, mtr_if and the moe_topk_router_top RTL.
module moe_topk_router_top_tb;

    typedef struct packed {
        logic [mtr_pkg::INDEX_W-1:0]  expert_index;
        logic [mtr_pkg::WEIGHT_W-1:0] weight;
        logic                         last_of_run;
    } gate_result_t;

    class gate_scoreboard;
        gate_result_t        gate_q[$];
        logic [mtr_pkg::LOGIT_W-1:0] score_mem[mtr_pkg::DEF_MAX_EXPERTS];
        int                  loaded;
        int                  peak;
        int unsigned         ne_reg;
        int unsigned         k_reg;
        int unsigned         norm_reg;
        int                  errors;
        int                  tokens;
        int                  results;
        longint unsigned     pow2_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
            48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

        function new();
            ne_reg = mtr_pkg::NUM_EXPERTS_RST;
            k_reg = mtr_pkg::NUM_SELECTED_RST;
            norm_reg = 1;
            errors = 0;
            tokens = 0;
            results = 0;
            drop_token();
        endfunction

        function void drop_token();
            loaded = 0;
            peak = -32768;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == mtr_pkg::REG_NUM_EXPERTS) ne_reg = val[8:0];
            else if (idx == mtr_pkg::REG_NUM_SELECTED) k_reg = val[6:0];
            else if (idx == mtr_pkg::REG_NORMALIZE) norm_reg = val[0];
            drop_token();
        endfunction

        function longint unsigned exp_neg(longint unsigned d);
            longint unsigned t, ip, j, r, m;
            t = (d * 94548 + 32768) >> 16;
            ip = t >> 10;
            j = (t >> 6) & 15;
            r = t & 63;
            m = pow2_tab[j] - (((pow2_tab[j] - pow2_tab[j+1]) * r + 32) >> 6);
            if (ip == 0) return m;
            if (ip >= 32) return 0;
            return (m + (longint'(1) << (ip - 1))) >> ip;
        endfunction

        function void note_logit(logic signed [mtr_pkg::LOGIT_W-1:0] x);
            longint unsigned ex[mtr_pkg::DEF_MAX_EXPERTS];
            bit              marks[mtr_pkg::DEF_MAX_EXPERTS];
            int              picks[$];
            longint unsigned sum, sel_sum, den, w;
            int              ne, k, best, d;
            bit              found;
            gate_result_t    res;
            ne = ne_reg;
            k = k_reg;
            if (ne < 1) ne = 1;
            if (ne > mtr_pkg::DEF_MAX_EXPERTS) ne = mtr_pkg::DEF_MAX_EXPERTS;
            if (k < 1) k = 1;
            if (k > mtr_pkg::DEF_MAX_SELECTED) k = mtr_pkg::DEF_MAX_SELECTED;
            if (k > ne) k = ne;
            if (loaded < mtr_pkg::DEF_MAX_EXPERTS) score_mem[loaded] = x;
            if (int'(x) > peak) peak = x;
            loaded++;
            if (loaded < ne) return;
            sum = 0;
            sel_sum = 0;
            for (int i = 0; i < ne; i++)
            begin
                d = peak - int'($signed(score_mem[i]));
                ex[i] = exp_neg(d > 0 ? d : 0);
                sum += ex[i];
                marks[i] = 0;
            end
            for (int s = 0; s < k; s++)
            begin
                best = 0;
                found = 0;
                for (int i = 0; i < ne; i++)
                    if (!marks[i] && (!found || ex[i] > ex[best]))
                    begin
                        best = i;
                        found = 1;
                    end
                marks[best] = 1;
                sel_sum += ex[best];
                picks.push_back(best);
            end
            den = norm_reg ? sel_sum : sum;
            for (int s = 0; s < k; s++)
            begin
                w = den ? (ex[picks[s]] * 65536 + den / 2) / den : 0;
                if (w > 65536) w = 65536;
                res.expert_index = mtr_pkg::INDEX_W'(picks[s]);
                res.weight = mtr_pkg::WEIGHT_W'(w);
                res.last_of_run = (s + 1 == k);
                gate_q.push_back(res);
            end
            tokens++;
            drop_token();
        endfunction

        function void check_result(gate_result_t got);
            gate_result_t want;
            results++;
            if (gate_q.size() == 0)
            begin
                $error("unexpected result: expert_index %0d weight %0d",
                       got.expert_index, got.weight);
                errors++;
                return;
            end
            want = gate_q.pop_front();
            if (got.expert_index !== want.expert_index)
            begin
                $error("expert_index expected %0d actual %0d", want.expert_index,
                       got.expert_index);
                errors++;
            end
            if (got.weight !== want.weight)
            begin
                $error("weight expected %0d actual %0d", want.weight, got.weight);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run expected %0d actual %0d", want.last_of_run,
                       got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mtr_pkg::APB_ADDR_W-1:0] paddr;
    logic [mtr_pkg::APB_DATA_W-1:0] pwdata;
    logic [mtr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    mtr_logit_if  lch();
    mtr_result_if rch();

    gate_scoreboard sb = new();
    int logits_sent = 0;
    int results_seen = 0;
    bit hold_req = 0;

    moe_topk_router_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .logit_ch  (lch),
        .result_ch (rch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("** moe_topk_router_top: FAILED **");
        $finish;
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        sb.write_reg(idx, val);
    endtask

    task automatic reg_read_check(input logic [1:0] idx, input logic [31:0] want);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1;
        @(negedge clk);
        if (prdata !== want)
        begin
            $error("prdata expected %0d actual %0d", want, prdata);
            sb.errors++;
        end
        @(posedge clk);
        psel <= 0;
        penable <= 0;
    endtask

    task automatic configure(input int ne, input int k, input int norm);
        reg_write(mtr_pkg::REG_NUM_EXPERTS, ne);
        reg_write(mtr_pkg::REG_NUM_SELECTED, k);
        reg_write(mtr_pkg::REG_NORMALIZE, norm);
    endtask

    task automatic send_logit(input logic signed [mtr_pkg::LOGIT_W-1:0] x);
        bit taken;
        while (!(logits_sent >= 100 && logits_sent < 160) && $urandom_range(0, 99) < 26)
        begin
            lch.valid <= 0;
            @(posedge clk);
        end
        lch.valid <= 1;
        lch.logit <= x;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = lch.ready;
            @(posedge clk);
        end
        sb.note_logit(x);
        logits_sent++;
    endtask

    task automatic end_burst();
        lch.valid <= 0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (sb.gate_q.size() > 0) @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    function automatic logic [mtr_pkg::LOGIT_W-1:0] pick_logit(int mode, int base);
        int v;
        case (mode)
            0: v = $signed($urandom_range(0, 65535) - 32768);
            1: v = base + $urandom_range(0, 3000) - 1500;
            2: v = base;
            default: v = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return mtr_pkg::LOGIT_W'(v);
    endfunction

    initial
    begin
        bit held;
        gate_result_t got;
        held = 0;
        rch.ready <= 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                rch.ready <= 0;
                repeat (500) @(posedge clk);
            end
            rch.ready <= (results_seen >= 80 && results_seen < 140) ||
                         ($urandom_range(0, 99) >= 26);
            @(negedge clk);
            if (rch.valid && rch.ready)
            begin
                got.expert_index = rch.expert_index;
                got.weight = rch.weight;
                got.last_of_run = rch.last_of_run;
                sb.check_result(got);
                results_seen++;
            end
        end
    end

    initial
    begin
        int ne, k, ntok, mode, base, cnt;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        lch.valid = 0;
        lch.logit = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        reg_read_check(mtr_pkg::REG_NUM_EXPERTS, 128);
        reg_read_check(mtr_pkg::REG_NUM_SELECTED, 8);
        reg_read_check(mtr_pkg::REG_NORMALIZE, 1);

        // single expert, zero selected clamps to one
        configure(1, 0, 0);
        send_logit(32767);
        send_logit(-32768);
        end_burst();
        wait_idle();

        // selection count above expert count, tiny exponentials
        configure(4, 127, 1);
        send_logit(32767);
        send_logit(-32768);
        send_logit(0);
        send_logit(-1);
        end_burst();
        wait_idle();

        // ties resolve to lowest index
        configure(3, 2, 0);
        repeat (3) send_logit(5);
        end_burst();
        wait_idle();

        // abandon partial tokens at the widest settings
        configure(256, 64, 1);
        send_logit(100);
        send_logit(-100);
        send_logit(7);
        end_burst();
        wait_idle();
        reg_write(mtr_pkg::REG_NUM_EXPERTS, 511);
        send_logit(1);
        end_burst();
        wait_idle();
        reg_write(mtr_pkg::REG_NUM_EXPERTS, 0);
        configure(5, 64, 1);
        send_logit(-32768);
        send_logit(1024);
        send_logit(1024);
        send_logit(-2048);
        send_logit(32767);
        end_burst();
        wait_idle();

        // hold the consumer while the next token waits at the input
        configure(6, 3, 0);
        hold_req = 1;
        repeat (12) send_logit(pick_logit(1, 0));
        end_burst();
        wait_idle();

        while (logits_sent < 245)
        begin
            ne = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            k = ($urandom_range(0, 99) < 70) ? $urandom_range(1, ne) : $urandom_range(0, 127);
            configure((ne == 1 && $urandom_range(0, 1)) ? 0 : ne, k, $urandom_range(0, 1));
            ntok = $urandom_range(1, 3);
            for (int t = 0; t < ntok; t++)
            begin
                mode = $urandom_range(0, 3);
                base = $signed($urandom_range(0, 65535) - 32768);
                cnt = (ne > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, ne - 1) : ne;
                for (int i = 0; i < cnt; i++)
                    send_logit(pick_logit($urandom_range(0, 4) == 0 ? 0 : mode, base));
                if (cnt < ne)
                begin
                    end_burst();
                    wait_idle();
                    reg_write(mtr_pkg::REG_NORMALIZE, $urandom_range(0, 1));
                end
            end
            end_burst();
            wait_idle();
        end

        wait_idle();
        repeat (200) @(posedge clk);
        $display("run: %0d logits, %0d tokens, %0d gating results checked",
                 logits_sent, sb.tokens, sb.results);
        $display("      expert counts 1..40 plus aborted 256/511, clamped and ties");
        if (sb.errors == 0 && sb.gate_q.size() == 0)
            $display("** moe_topk_router_top: PASSED **");
        else
            $display("** moe_topk_router_top: FAILED **");
        $finish;
    end

endmodule
